// ===== rtl/rspe_pkg.sv =====
// ----------------------------------------------------------------------------
// Register stack p-code executor package
// Shared constants, item types, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package rspe_pkg;

	localparam int REG_COUNT   = 16;
	localparam int STACK_DEPTH = 2048;
	localparam int CODE_DEPTH  = 512;
	localparam int MAX_LEVEL   = 3;

	localparam int DATA_W = 32;
	localparam int REG_AW = $clog2(REG_COUNT);
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int LVL_W  = $clog2(MAX_LEVEL + 1);

	localparam int CMD_W  = 5;
	localparam int RIDX_W = 4;
	localparam int LEV_W  = 2;
	localparam int OPND_W = 16;
	localparam int PC_W   = 10;
	localparam int BP_W   = 11;
	localparam int SP_W   = 12;
	localparam int PLEN_W = 10;
	localparam int STAT_W = 2;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [0:0]        CFG_PLEN   = 1'b0;
	localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(512);
	localparam logic [BP_W-1:0]   BP_RESET   = BP_W'(1);

	typedef enum logic [CMD_W-1:0] {
		OP_NOP = 5'd0,
		OP_LIT = 5'd1,
		OP_RTN = 5'd2,
		OP_LOD = 5'd3,
		OP_STO = 5'd4,
		OP_CAL = 5'd5,
		OP_INC = 5'd6,
		OP_JMP = 5'd7,
		OP_JPC = 5'd8,
		OP_PRT = 5'd9,
		OP_RED = 5'd10,
		OP_HLT = 5'd11,
		OP_NEG = 5'd12,
		OP_ADD = 5'd13,
		OP_SUB = 5'd14,
		OP_MUL = 5'd15,
		OP_DIV = 5'd16,
		OP_ODD = 5'd17,
		OP_MOD = 5'd18,
		OP_EQL = 5'd19,
		OP_NEQ = 5'd20,
		OP_LSS = 5'd21,
		OP_LEQ = 5'd22,
		OP_GTR = 5'd23,
		OP_GEQ = 5'd24
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_DIVZ  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_B,
		S_RD_R,
		S_EXEC,
		S_DIV,
		S_WALK,
		S_WALK_W,
		S_ACCESS,
		S_LOAD_W,
		S_CALL,
		S_RTN_A,
		S_RTN_B,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [RIDX_W-1:0]        reg_index;
		logic [LEV_W-1:0]         level;
		logic [OPND_W-1:0]        operand;
		logic signed [DATA_W-1:0] read_value;
	} in_item_t;

	typedef struct packed {
		logic [PC_W-1:0]          next_pc;
		logic [BP_W-1:0]          base_pointer;
		logic [SP_W-1:0]          stack_pointer;
		logic                     print_valid;
		logic [RIDX_W-1:0]        print_reg;
		logic signed [DATA_W-1:0] print_value;
		logic                     halted;
		logic [STAT_W-1:0]        status;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== rtl/rspe_if.sv =====
// ----------------------------------------------------------------------------
// Register stack p-code executor channels
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface rspe_in_if;
	logic              valid;
	logic              ready;
	rspe_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rspe_out_if;
	logic               valid;
	logic               ready;
	rspe_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rspe_div.sv =====
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rspe_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rspe_pkg::div_req_t  req,
	output rspe_pkg::div_rsp_t  rsp
);

	localparam int DW  = rspe_pkg::DATA_W;
	localparam int CNW = $clog2(DW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  quo_q;
	logic [DW-1:0]  dvs_q;
	logic           qneg_q;
	logic           rneg_q;

	logic [DW:0]    trial;
	logic [DW-1:0]  dvd_mag;
	logic [DW-1:0]  dvs_mag;

	assign dvd_mag = req.dividend[DW-1] ? (~req.dividend + DW'(1)) : req.dividend;
	assign dvs_mag = req.divisor[DW-1] ? (~req.divisor + DW'(1)) : req.divisor;
	assign trial   = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= dvd_mag;
			dvs_q  <= dvs_mag;
			qneg_q <= req.dividend[DW-1] ^ req.divisor[DW-1];
			rneg_q <= req.dividend[DW-1];
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = qneg_q ? (~quo_q + DW'(1)) : quo_q;
	assign rsp.remainder = rneg_q ? (~rem_q + DW'(1)) : rem_q;

endmodule

// ===== rtl/register_stack_pcode_executor.sv =====
// ----------------------------------------------------------------------------
// Register stack p-code executor
// PM/0 register machine executing one instruction item per handshake.
// ----------------------------------------------------------------------------
// Each instruction item runs to completion before the next one is taken, and
// one result item comes back for every instruction item. The three source
// registers are read one per cycle from the register file. Division and
// modulo go through a shared bit-serial divider. Load, store and call walk
// the static links with one stack memory read per level, and a call then
// writes its four frame words one per cycle. Return reads two frame words.
// After reset the block sweeps the 2048-word stack memory to zero, one word
// per cycle, and takes no instruction item until the sweep is done; the
// program length register can be written meanwhile. A result item waits in
// an output register; a new instruction item is taken once that register is
// empty or is being read in the same cycle.
// ----------------------------------------------------------------------------
module register_stack_pcode_executor (
	input  logic                        clk,
	input  logic                        arst_n,
	rspe_in_if.sink                     instr,
	rspe_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rspe_pkg::APB_AW-1:0] paddr,
	input  logic [rspe_pkg::APB_DW-1:0] pwdata,
	output logic [rspe_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int DW     = rspe_pkg::DATA_W;
	localparam int REG_AW = rspe_pkg::REG_AW;
	localparam int STK_AW = rspe_pkg::STK_AW;
	localparam int LVL_W  = rspe_pkg::LVL_W;
	localparam int PC_W   = rspe_pkg::PC_W;
	localparam int BP_W   = rspe_pkg::BP_W;
	localparam int SP_W   = rspe_pkg::SP_W;
	localparam int PLEN_W = rspe_pkg::PLEN_W;
	localparam int RIDX_W = rspe_pkg::RIDX_W;

	// Configuration register.
	logic [PLEN_W-1:0] plen_q;
	logic [PLEN_W-1:0] len;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == rspe_pkg::CFG_PLEN);
	assign prdata = (paddr[2] == rspe_pkg::CFG_PLEN) ? rspe_pkg::APB_DW'(plen_q) : '0;
	assign len    = (plen_q > PLEN_W'(rspe_pkg::CODE_DEPTH)) ?
	                PLEN_W'(rspe_pkg::CODE_DEPTH) : plen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= rspe_pkg::PLEN_RESET;
		end else if (cfg_wr) begin
			plen_q <= pwdata[PLEN_W-1:0];
		end
	end

	// Sequencer and machine registers.
	rspe_pkg::state_t    state_q, state_d;
	rspe_pkg::in_item_t  instr_q, instr_d;
	rspe_pkg::out_item_t out_q, out_d;
	logic                out_valid_q, out_valid_d;
	logic [DW-1:0]       pcn_q, pcn_d;
	logic [DW-1:0]       a_q, a_d;
	logic [DW-1:0]       b_q, b_d;
	logic [DW-1:0]       r_q, r_d;
	logic [DW-1:0]       base_q, base_d;
	logic [DW-1:0]       t_q, t_d;
	logic [LVL_W-1:0]    lvl_q, lvl_d;
	logic [1:0]          cal_q, cal_d;
	logic [STK_AW-1:0]   clr_q, clr_d;
	logic [PC_W-1:0]     pc_q, pc_d;
	logic [BP_W-1:0]     bp_q, bp_d;
	logic [SP_W-1:0]     sp_q, sp_d;
	logic                stopped_q, stopped_d;
	rspe_pkg::status_t   status_q, status_d;
	logic                pvalid_q, pvalid_d;
	logic [DW-1:0]       pval_q, pval_d;

	// Register file: one read port with registered data, valid bit per entry.
	logic [DW-1:0]          rf_mem [rspe_pkg::REG_COUNT];
	logic [rspe_pkg::REG_COUNT-1:0] rf_vld_q;
	logic [REG_AW-1:0]      rf_raddr;
	logic [DW-1:0]          rf_rdata_q;
	logic                   rf_we;
	logic [DW-1:0]          rf_wdata;
	logic [REG_AW-1:0]      rf_waddr;

	// Stack memory: one write port, one registered read port.
	logic [DW-1:0]     stk_mem [rspe_pkg::STACK_DEPTH];
	logic [STK_AW-1:0] stk_raddr;
	logic [DW-1:0]     stk_rdata_q;
	logic              stk_we;
	logic [STK_AW-1:0] stk_waddr;
	logic [DW-1:0]     stk_wdata;

	rspe_pkg::div_req_t div_req;
	rspe_pkg::div_rsp_t div_rsp;

	rspe_pkg::opcode_t op;
	logic              in_ready;
	logic [DW:0]       walk_addr;
	logic [DW:0]       acc_addr;
	logic              halt;

	assign op        = rspe_pkg::opcode_t'(instr_q.command);
	assign rf_waddr  = instr_q.reg_index[REG_AW-1:0];
	assign walk_addr = (DW+1)'(base_q) + (DW+1)'(1);
	assign acc_addr  = (DW+1)'(base_q) + (DW+1)'(instr_q.operand);
	assign in_ready  = (state_q == rspe_pkg::S_IDLE) && (!out_valid_q || result.ready);

	assign instr.ready  = in_ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	rspe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.dividend = a_q;
	assign div_req.divisor  = b_q;

	always_comb begin
		state_d     = state_q;
		instr_d     = instr_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !result.ready;
		pcn_d       = pcn_q;
		a_d         = a_q;
		b_d         = b_q;
		r_d         = r_q;
		base_d      = base_q;
		t_d         = t_q;
		lvl_d       = lvl_q;
		cal_d       = cal_q;
		clr_d       = clr_q;
		pc_d        = pc_q;
		bp_d        = bp_q;
		sp_d        = sp_q;
		stopped_d   = stopped_q;
		status_d    = status_q;
		pvalid_d    = pvalid_q;
		pval_d      = pval_q;
		rf_raddr    = '0;
		rf_we       = 1'b0;
		rf_wdata    = '0;
		stk_raddr   = '0;
		stk_we      = 1'b0;
		stk_waddr   = '0;
		stk_wdata   = '0;
		div_req.start = 1'b0;
		halt        = 1'b0;

		unique case (state_q)
			rspe_pkg::S_CLEAR: begin
				// Zero the stack memory one word per cycle.
				stk_we    = 1'b1;
				stk_waddr = clr_q;
				clr_d     = clr_q + STK_AW'(1);
				if (clr_q == STK_AW'(rspe_pkg::STACK_DEPTH - 1)) begin
					state_d = rspe_pkg::S_IDLE;
				end
			end
			rspe_pkg::S_IDLE: begin
				rf_raddr = REG_AW'(instr.data.level);
				if (instr.valid && in_ready) begin
					instr_d  = instr.data;
					pcn_d    = DW'(pc_q) + DW'(1);
					status_d = rspe_pkg::STAT_OK;
					pvalid_d = 1'b0;
					pval_d   = '0;
					// A stopped machine only reports its halted state.
					state_d  = stopped_q ? rspe_pkg::S_FIN : rspe_pkg::S_RD_B;
				end
			end
			rspe_pkg::S_RD_B: begin
				a_d      = rf_rdata_q;
				rf_raddr = instr_q.operand[REG_AW-1:0];
				state_d  = rspe_pkg::S_RD_R;
			end
			rspe_pkg::S_RD_R: begin
				b_d      = rf_rdata_q;
				rf_raddr = instr_q.reg_index[REG_AW-1:0];
				state_d  = rspe_pkg::S_EXEC;
			end
			rspe_pkg::S_EXEC: begin
				r_d     = rf_rdata_q;
				base_d  = DW'(bp_q);
				lvl_d   = (LVL_W'(instr_q.level) > LVL_W'(rspe_pkg::MAX_LEVEL) ||
				           (rspe_pkg::LEV_W > LVL_W && (instr_q.level >> LVL_W) != '0)) ?
				          LVL_W'(rspe_pkg::MAX_LEVEL) : LVL_W'(instr_q.level);
				state_d = rspe_pkg::S_FIN;
				unique case (op)
					rspe_pkg::OP_LIT: begin
						rf_we    = 1'b1;
						rf_wdata = DW'(instr_q.operand);
					end
					rspe_pkg::OP_RTN: begin
						if (bp_q == '0 || ((DW+1)'(bp_q) + (DW+1)'(3)) >=
						    (DW+1)'(rspe_pkg::STACK_DEPTH)) begin
							status_d = rspe_pkg::STAT_RANGE;
						end else begin
							stk_raddr = STK_AW'(bp_q) + STK_AW'(2);
							state_d   = rspe_pkg::S_RTN_A;
						end
					end
					rspe_pkg::OP_LOD, rspe_pkg::OP_STO, rspe_pkg::OP_CAL: begin
						state_d = rspe_pkg::S_WALK;
					end
					rspe_pkg::OP_INC: begin
						if (((DW+1)'(sp_q) + (DW+1)'(instr_q.operand)) >
						    (DW+1)'(rspe_pkg::STACK_DEPTH)) begin
							status_d = rspe_pkg::STAT_RANGE;
						end else begin
							sp_d = sp_q + SP_W'(instr_q.operand);
						end
					end
					rspe_pkg::OP_JMP: begin
						pcn_d = DW'(instr_q.operand);
					end
					rspe_pkg::OP_JPC: begin
						if (rf_rdata_q == '0) begin
							pcn_d = DW'(instr_q.operand);
						end
					end
					rspe_pkg::OP_PRT: begin
						pvalid_d = 1'b1;
						pval_d   = rf_rdata_q;
					end
					rspe_pkg::OP_RED: begin
						rf_we    = 1'b1;
						rf_wdata = instr_q.read_value;
					end
					rspe_pkg::OP_NEG: begin
						rf_we    = 1'b1;
						rf_wdata = DW'(0) - a_q;
					end
					rspe_pkg::OP_ADD: begin
						rf_we    = 1'b1;
						rf_wdata = a_q + b_q;
					end
					rspe_pkg::OP_SUB: begin
						rf_we    = 1'b1;
						rf_wdata = a_q - b_q;
					end
					rspe_pkg::OP_MUL: begin
						rf_we    = 1'b1;
						rf_wdata = a_q * b_q;
					end
					rspe_pkg::OP_DIV, rspe_pkg::OP_MOD: begin
						if (b_q == '0) begin
							status_d = rspe_pkg::STAT_DIVZ;
						end else begin
							div_req.start = 1'b1;
							state_d       = rspe_pkg::S_DIV;
						end
					end
					rspe_pkg::OP_ODD: begin
						// Truncated remainder by two keeps the sign of the value.
						rf_we    = 1'b1;
						rf_wdata = rf_rdata_q[0] ? (rf_rdata_q[DW-1] ? '1 : DW'(1)) : '0;
					end
					rspe_pkg::OP_EQL: begin
						rf_we    = 1'b1;
						rf_wdata = DW'(a_q == b_q);
					end
					rspe_pkg::OP_NEQ: begin
						rf_we    = 1'b1;
						rf_wdata = DW'(a_q != b_q);
					end
					rspe_pkg::OP_LSS: begin
						rf_we    = 1'b1;
						rf_wdata = DW'($signed(a_q) < $signed(b_q));
					end
					rspe_pkg::OP_LEQ: begin
						rf_we    = 1'b1;
						rf_wdata = DW'($signed(a_q) <= $signed(b_q));
					end
					rspe_pkg::OP_GTR: begin
						rf_we    = 1'b1;
						rf_wdata = DW'($signed(a_q) > $signed(b_q));
					end
					rspe_pkg::OP_GEQ: begin
						rf_we    = 1'b1;
						rf_wdata = DW'($signed(a_q) >= $signed(b_q));
					end
					default: begin
						// No-op, halt and the unused opcodes only advance the PC here.
					end
				endcase
			end
			rspe_pkg::S_DIV: begin
				if (div_rsp.done) begin
					rf_we    = 1'b1;
					rf_wdata = (op == rspe_pkg::OP_DIV) ? div_rsp.quotient :
					           div_rsp.remainder;
					state_d  = rspe_pkg::S_FIN;
				end
			end
			rspe_pkg::S_WALK: begin
				if (lvl_q == '0) begin
					state_d = rspe_pkg::S_ACCESS;
				end else if (walk_addr >= (DW+1)'(rspe_pkg::STACK_DEPTH)) begin
					status_d = rspe_pkg::STAT_RANGE;
					state_d  = rspe_pkg::S_FIN;
				end else begin
					stk_raddr = walk_addr[STK_AW-1:0];
					state_d   = rspe_pkg::S_WALK_W;
				end
			end
			rspe_pkg::S_WALK_W: begin
				base_d  = stk_rdata_q;
				lvl_d   = lvl_q - LVL_W'(1);
				state_d = rspe_pkg::S_WALK;
			end
			rspe_pkg::S_ACCESS: begin
				state_d = rspe_pkg::S_FIN;
				if (op == rspe_pkg::OP_CAL) begin
					if (((DW+1)'(sp_q) + (DW+1)'(4)) >= (DW+1)'(rspe_pkg::STACK_DEPTH)) begin
						status_d = rspe_pkg::STAT_RANGE;
					end else begin
						cal_d   = '0;
						state_d = rspe_pkg::S_CALL;
					end
				end else if (acc_addr >= (DW+1)'(rspe_pkg::STACK_DEPTH)) begin
					status_d = rspe_pkg::STAT_RANGE;
				end else if (op == rspe_pkg::OP_LOD) begin
					stk_raddr = acc_addr[STK_AW-1:0];
					state_d   = rspe_pkg::S_LOAD_W;
				end else begin
					stk_we    = 1'b1;
					stk_waddr = acc_addr[STK_AW-1:0];
					stk_wdata = r_q;
				end
			end
			rspe_pkg::S_LOAD_W: begin
				rf_we    = 1'b1;
				rf_wdata = stk_rdata_q;
				state_d  = rspe_pkg::S_FIN;
			end
			rspe_pkg::S_CALL: begin
				// Frame words: return value, static link, dynamic link, return address.
				stk_we    = 1'b1;
				stk_waddr = sp_q[STK_AW-1:0] + STK_AW'(1) + STK_AW'(cal_q);
				unique case (cal_q)
					2'd0: stk_wdata = '0;
					2'd1: stk_wdata = base_q;
					2'd2: stk_wdata = DW'(bp_q);
					2'd3: stk_wdata = pcn_q;
				endcase
				cal_d = cal_q + 2'd1;
				if (cal_q == 2'd3) begin
					bp_d    = BP_W'(sp_q + SP_W'(1));
					pcn_d   = DW'(instr_q.operand);
					state_d = rspe_pkg::S_FIN;
				end
			end
			rspe_pkg::S_RTN_A: begin
				t_d       = stk_rdata_q;
				stk_raddr = STK_AW'(bp_q) + STK_AW'(3);
				state_d   = rspe_pkg::S_RTN_B;
			end
			rspe_pkg::S_RTN_B: begin
				if (t_q >= DW'(rspe_pkg::STACK_DEPTH)) begin
					status_d = rspe_pkg::STAT_RANGE;
				end else begin
					pcn_d = stk_rdata_q;
					sp_d  = SP_W'(bp_q) - SP_W'(1);
					bp_d  = t_q[BP_W-1:0];
				end
				state_d = rspe_pkg::S_FIN;
			end
			rspe_pkg::S_FIN: begin
				halt = stopped_q || (pcn_q >= DW'(len)) || (op == rspe_pkg::OP_HLT);
				if (halt) begin
					pc_d      = '0;
					sp_d      = '0;
					bp_d      = '0;
					stopped_d = 1'b1;
				end else begin
					pc_d = pcn_q[PC_W-1:0];
				end
				out_d.next_pc       = pc_d;
				out_d.base_pointer  = bp_d;
				out_d.stack_pointer = sp_d;
				out_d.print_valid   = pvalid_q;
				out_d.print_reg     = pvalid_q ?
				                      RIDX_W'(instr_q.reg_index[REG_AW-1:0]) : '0;
				out_d.print_value   = pval_q;
				out_d.halted        = stopped_d;
				out_d.status        = status_q;
				out_valid_d         = 1'b1;
				state_d             = rspe_pkg::S_IDLE;
			end
			default: begin
				state_d = rspe_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rspe_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
			pc_q        <= '0;
			bp_q        <= rspe_pkg::BP_RESET;
			sp_q        <= '0;
			stopped_q   <= 1'b0;
			rf_vld_q    <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			clr_q       <= clr_d;
			pc_q        <= pc_d;
			bp_q        <= bp_d;
			sp_q        <= sp_d;
			stopped_q   <= stopped_d;
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		instr_q  <= instr_d;
		out_q    <= out_d;
		pcn_q    <= pcn_d;
		a_q      <= a_d;
		b_q      <= b_d;
		r_q      <= r_d;
		base_q   <= base_d;
		t_q      <= t_d;
		lvl_q    <= lvl_d;
		cal_q    <= cal_d;
		status_q <= status_d;
		pvalid_q <= pvalid_d;
		pval_q   <= pval_d;
	end

	// Register file storage; an entry never written reads as zero.
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		rf_rdata_q <= rf_vld_q[rf_raddr] ? rf_mem[rf_raddr] : '0;
	end

	// Stack memory storage.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	// Once halted, the machine stays halted until reset.
	a_stopped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halted state was left without reset");

	// A halted machine keeps its pointers cleared.
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (pc_q == '0 && bp_q == '0 && sp_q == '0))
		else $error("pointers nonzero while halted");

	// The divider finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == rspe_pkg::S_DIV)
		else $error("divider result outside the divide wait");

	// No instruction item is taken during the stack clearing sweep.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rspe_pkg::S_CLEAR |-> !instr.ready)
		else $error("instruction item taken while clearing the stack");

	// A result item appears only at the end of an instruction.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == rspe_pkg::S_FIN)
		else $error("result item raised outside the final step");

endmodule
